FILE: hw/rtl/scacc_pkg.sv
`default_nettype none
package scacc_pkg;

	localparam int unsigned NUM_W = 38;
	localparam int unsigned DEN_W = 22;
	localparam int unsigned QUO_W = 17;

	localparam logic [2:0] CFG_PSEUDOCOUNT = 3'd0;
	localparam logic [2:0] CFG_MIN_DEPTH   = 3'd1;
	localparam logic [2:0] CFG_BAND_LOW    = 3'd2;
	localparam logic [2:0] CFG_BAND_HIGH   = 3'd3;
	localparam logic [2:0] CFG_MIN_GAP     = 3'd4;
	localparam logic [2:0] CFG_MAX_LOW     = 3'd5;
	localparam logic [2:0] CFG_ALLOW_NO_HI = 3'd6;
	localparam logic [2:0] CFG_ALLOW_NO_LO = 3'd7;

	localparam logic       OP_ACCUM   = 1'b0;
	localparam logic       OP_VERDICT = 1'b1;

	localparam logic [1:0] DIGIT_LOW  = 2'd0;
	localparam logic [1:0] DIGIT_HIGH = 2'd1;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	typedef struct packed {
		logic [17:0]        min_high;
		logic signed [17:0] max_low;
		logic [23:0]        sum_high;
		logic [23:0]        sum_low;
		logic [7:0]         cnt_high;
		logic [7:0]         cnt_low;
		logic [7:0]         ld_cnt;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	localparam entry_t ENTRY_CLEAR = '{
		min_high: 18'd131072,
		max_low:  -18'sd65536,
		sum_high: 24'd0,
		sum_low:  24'd0,
		cnt_high: 8'd0,
		cnt_low:  8'd0,
		ld_cnt:   8'd0
	};

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

endpackage
`default_nettype wire

FILE: hw/rtl/scacc_ram.sv
`default_nettype none
module scacc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/scacc_div.sv
`default_nettype none
module scacc_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire scacc_pkg::div_req_t            req,
	output logic                                done,
	output logic [scacc_pkg::QUO_W-1:0]         quo
);

	logic [scacc_pkg::NUM_W-1:0] rem_q;
	logic [scacc_pkg::NUM_W-1:0] dsh_q;
	logic [scacc_pkg::QUO_W-1:0] quo_q;
	logic [4:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic                        fits;

	// Restoring division, one quotient bit per cycle, most significant first.
	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= {req.den, {(scacc_pkg::QUO_W-1){1'b0}}};
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[scacc_pkg::QUO_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 5'(scacc_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

FILE: hw/rtl/site_contrast_accumulator.sv
// Per-site contrast accumulator. Each site's evidence (side extremes, sums,
// counts and a low-depth count) sits in one synchronous RAM word that is read,
// updated and written back, one transaction at a time. A fraction and the two
// side means come from a shared restoring divider that yields one quotient bit
// per cycle, which sets the pace. An accumulate reads, loads, divides once and
// writes back; a low-depth accumulate skips the division, an ignored-side
// accumulate ends after the load with no write-back, a verdict runs two
// divisions, and an accumulate to a site beyond SITES is dropped without a RAM
// access. After reset the RAM is cleared one site per cycle, during which no
// input is taken; configuration writes are taken at any time. A verdict waits
// in an output register while the next transaction is accepted.
`default_nettype none
module site_contrast_accumulator #(
	parameter int unsigned SITES = 65536
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               operation,
	input  wire logic [15:0]        site,
	input  wire logic [15:0]        meth_count,
	input  wire logic [15:0]        unmeth_count,
	input  wire logic [1:0]         group_digit,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             site_out,
	output logic                    eligible,
	output logic                    band_pass,
	output logic signed [16:0]      rank_value
);

	localparam int unsigned AW = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int unsigned EW = scacc_pkg::ENTRY_W;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_LOAD = 3'd3;
	localparam logic [2:0] S_DIVA = 3'd4;
	localparam logic [2:0] S_DIVB = 3'd5;
	localparam logic [2:0] S_WR   = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0]  state_q;
	logic [AW-1:0] clr_q;

	logic [7:0]  pc_q;
	logic [15:0] min_depth_q;
	logic [15:0] band_low_q;
	logic [15:0] band_high_q;
	logic [15:0] min_gap_q;
	logic [7:0]  max_low_q;
	logic        allow_hi_q;
	logic        allow_lo_q;

	logic        op_q;
	logic [15:0] site_q;
	logic [15:0] m_q;
	logic [15:0] u_q;
	logic [1:0]  digit_q;
	logic        inside_q;

	scacc_pkg::entry_t ent_q;
	scacc_pkg::entry_t ent_in;
	scacc_pkg::entry_t ent_ld;
	scacc_pkg::entry_t ent_upd;
	logic [EW-1:0]     rdata;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [EW-1:0]     ram_wdata;

	logic [scacc_pkg::QUO_W-1:0] mean_hi_q;
	logic [scacc_pkg::QUO_W-1:0] quo;
	logic                        div_done;
	scacc_pkg::div_req_t         div_req;

	logic        accept;
	logic        inside_in;
	logic [16:0] cov;
	logic        low_depth;
	logic [scacc_pkg::DEN_W-1:0] frac_den;
	logic [scacc_pkg::NUM_W-1:0] frac_num;

	logic        ok;
	logic        pass;
	logic [16:0] mean_hi;
	logic [16:0] mean_lo;
	logic signed [17:0] diff;
	logic signed [16:0] rank;
	logic signed [18:0] gap;
	logic        out_free;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE;
	assign inside_in = 32'(site) < SITES;
	assign out_free  = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= 8'd48;
			min_depth_q <= 16'd1;
			band_low_q  <= 16'd19661;
			band_high_q <= 16'd45875;
			min_gap_q   <= 16'd0;
			max_low_q   <= 8'd0;
			allow_hi_q  <= 1'b0;
			allow_lo_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				scacc_pkg::CFG_PSEUDOCOUNT: pc_q        <= cfg_data[7:0];
				scacc_pkg::CFG_MIN_DEPTH:   min_depth_q <= cfg_data;
				scacc_pkg::CFG_BAND_LOW:    band_low_q  <= cfg_data;
				scacc_pkg::CFG_BAND_HIGH:   band_high_q <= cfg_data;
				scacc_pkg::CFG_MIN_GAP:     min_gap_q   <= cfg_data;
				scacc_pkg::CFG_MAX_LOW:     max_low_q   <= cfg_data[7:0];
				scacc_pkg::CFG_ALLOW_NO_HI: allow_hi_q  <= cfg_data[0];
				scacc_pkg::CFG_ALLOW_NO_LO: allow_lo_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// An out-of-range site reads as a freshly cleared one.
	assign ent_in = inside_q ? scacc_pkg::entry_t'(rdata) : scacc_pkg::ENTRY_CLEAR;

	assign cov       = {1'b0, m_q} + {1'b0, u_q};
	assign low_depth = (cov < {1'b0, min_depth_q}) || (cov == 17'd0 && pc_q == 8'd0);
	assign frac_den  = {1'b0, cov, 4'b0} + {13'b0, pc_q, 1'b0};
	assign frac_num  = {1'b0, ({1'b0, m_q, 4'b0} + {13'b0, pc_q}), 16'b0}
		+ {17'b0, frac_den[scacc_pkg::DEN_W-1:1]};

	always_comb begin
		ent_ld = ent_in;
		if (op_q == scacc_pkg::OP_ACCUM && low_depth
			&& ent_in.ld_cnt != scacc_pkg::COUNT_MAX) begin
			ent_ld.ld_cnt = ent_in.ld_cnt + 8'd1;
		end
	end

	always_comb begin
		div_req = '0;
		if (state_q == S_LOAD) begin
			if (op_q == scacc_pkg::OP_VERDICT) begin
				div_req.start = 1'b1;
				div_req.num   = {14'b0, ent_in.sum_high} + {31'b0, ent_in.cnt_high[7:1]};
				div_req.den   = {14'b0, ent_in.cnt_high};
			end else if (!low_depth && digit_q[1] == 1'b0) begin
				div_req.start = 1'b1;
				div_req.num   = frac_num;
				div_req.den   = frac_den;
			end
		end else if (state_q == S_DIVA && div_done && op_q == scacc_pkg::OP_VERDICT) begin
			div_req.start = 1'b1;
			div_req.num   = {14'b0, ent_q.sum_low} + {31'b0, ent_q.cnt_low[7:1]};
			div_req.den   = {14'b0, ent_q.cnt_low};
		end
	end

	always_comb begin
		ent_upd = ent_q;
		if (digit_q == scacc_pkg::DIGIT_HIGH) begin
			if ({1'b0, quo} < ent_q.min_high) begin
				ent_upd.min_high = {1'b0, quo};
			end
			if (ent_q.cnt_high != scacc_pkg::COUNT_MAX) begin
				ent_upd.sum_high = ent_q.sum_high + {7'b0, quo};
				ent_upd.cnt_high = ent_q.cnt_high + 8'd1;
			end
		end else begin
			if ($signed({1'b0, quo}) > ent_q.max_low) begin
				ent_upd.max_low = $signed({1'b0, quo});
			end
			if (ent_q.cnt_low != scacc_pkg::COUNT_MAX) begin
				ent_upd.sum_low = ent_q.sum_low + {7'b0, quo};
				ent_upd.cnt_low = ent_q.cnt_low + 8'd1;
			end
		end
	end

	assign mean_hi = (ent_q.cnt_high == 8'd0) ? 17'd0 : mean_hi_q;
	assign mean_lo = (ent_q.cnt_low == 8'd0) ? 17'd0 : quo;
	assign diff    = $signed({1'b0, mean_hi}) - $signed({1'b0, mean_lo});
	assign gap     = $signed({1'b0, ent_q.min_high}) - 19'(ent_q.max_low);

	always_comb begin
		ok = 1'b1;
		if (ent_q.cnt_high == 8'd0 && !allow_hi_q) ok = 1'b0;
		if (ent_q.cnt_low == 8'd0 && !allow_lo_q) ok = 1'b0;
		if (ent_q.ld_cnt > max_low_q) ok = 1'b0;
		if (diff > 18'sd65535) begin
			rank = 17'sd65535;
		end else if (diff < -18'sd65535) begin
			rank = -17'sd65535;
		end else begin
			rank = diff[16:0];
		end
		if (min_gap_q != 16'd0) begin
			pass = gap >= $signed({3'b0, min_gap_q});
		end else begin
			pass = (ent_q.max_low <= $signed({2'b0, band_low_q}))
				&& (ent_q.min_high >= {2'b0, band_high_q});
		end
		if (!ok) begin
			pass = 1'b0;
			rank = '0;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(site_q);
		ram_wdata = ent_q;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = scacc_pkg::ENTRY_CLEAR;
			end
			S_WR: ram_we = 1'b1;
			S_OUT: begin
				ram_we    = out_free && inside_q;
				ram_wdata = scacc_pkg::ENTRY_CLEAR;
			end
			default: ;
		endcase
	end

	scacc_ram #(
		.WIDTH(EW),
		.DEPTH(SITES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (state_q == S_RD),
		.raddr (AW'(site_q)),
		.rdata (rdata)
	);

	scacc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			site_q   <= site;
			m_q      <= meth_count;
			u_q      <= unmeth_count;
			digit_q  <= group_digit;
			inside_q <= inside_in;
		end
		if (state_q == S_LOAD) begin
			ent_q <= ent_ld;
		end
		if (state_q == S_DIVA && div_done) begin
			if (op_q == scacc_pkg::OP_ACCUM) begin
				ent_q <= ent_upd;
			end else begin
				mean_hi_q <= quo;
			end
		end
		if (state_q == S_OUT && out_free) begin
			site_out   <= site_q;
			eligible   <= ok;
			band_pass  <= pass;
			rank_value <= rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			out_valid <= (out_valid && out_stall) || (state_q == S_OUT && out_free);
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(SITES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (operation == scacc_pkg::OP_ACCUM && !inside_in) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_LOAD;
				S_LOAD: begin
					if (op_q == scacc_pkg::OP_VERDICT) begin
						state_q <= S_DIVA;
					end else if (low_depth) begin
						state_q <= S_WR;
					end else if (digit_q[1]) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIVA;
					end
				end
				S_DIVA: begin
					if (div_done) begin
						state_q <= (op_q == scacc_pkg::OP_ACCUM) ? S_WR : S_DIVB;
					end
				end
				S_DIVB: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_WR: state_q <= S_IDLE;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;

	localparam int unsigned LIMIT = 1500000;
	localparam int unsigned SETTLE = 64;
	localparam int MIN_HIGH_CLR = 131072;
	localparam int MAX_LOW_CLR = -65536;

	typedef struct {
		int          mn_hi;
		int          mx_lo;
		int unsigned s_hi;
		int unsigned s_lo;
		int unsigned n_hi;
		int unsigned n_lo;
		int unsigned n_ld;
	} evidence_t;

	typedef struct {
		logic [15:0]        site_id;
		logic               elig;
		logic               pass;
		logic signed [16:0] rank;
	} verdict_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               operation = scacc_pkg::OP_ACCUM;
	logic [15:0]        site = '0;
	logic [15:0]        meth_count = '0;
	logic [15:0]        unmeth_count = '0;
	logic [1:0]         group_digit = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        site_out;
	logic               eligible;
	logic               band_pass;
	logic signed [16:0] rank_value;

	// Shadow of the block's registers and per-site evidence.
	int unsigned pc_q = 48, min_depth_q = 1, band_low_q = 19661, band_high_q = 45875;
	int unsigned min_gap_q = 0, max_ld_q = 0, allow_no_hi_q = 0, allow_no_lo_q = 0;
	evidence_t   evidence[int unsigned];
	verdict_t    pending_verdicts[$];

	int unsigned failures = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;
	bit          hold_request = 1'b0;
	int unsigned hold_left = 0;
	int unsigned stall_mode = 0;

	site_contrast_accumulator DUT (
		.clk, .arst_n, .cfg_wr_en, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .operation, .site, .meth_count, .unmeth_count,
		.group_digit, .out_valid, .out_stall, .site_out, .eligible, .band_pass,
		.rank_value
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic evidence_t cleared();
		evidence_t e;
		e.mn_hi = MIN_HIGH_CLR;
		e.mx_lo = MAX_LOW_CLR;
		e.s_hi = 0;
		e.s_lo = 0;
		e.n_hi = 0;
		e.n_lo = 0;
		e.n_ld = 0;
		return e;
	endfunction

	function automatic int unsigned rounded_mean(int unsigned sum, int unsigned n);
		if (n == 0)
			return 0;
		return (sum + n / 2) / n;
	endfunction

	// Updates the shadow state for one accepted transaction and queues its verdict.
	task automatic update_evidence(logic op, logic [15:0] s, logic [15:0] m,
			logic [15:0] u, logic [1:0] d);
		evidence_t          e;
		longint unsigned    cov, num, den;
		int                 f, r;
		verdict_t           v;
		e = evidence.exists(s) ? evidence[s] : cleared();
		if (op == scacc_pkg::OP_ACCUM) begin
			cov = longint'(m) + longint'(u);
			if (cov < min_depth_q || (cov == 0 && pc_q == 0)) begin
				if (e.n_ld < 255)
					e.n_ld++;
			end else if (d == scacc_pkg::DIGIT_HIGH || d == scacc_pkg::DIGIT_LOW) begin
				num = (longint'(m) * 16 + pc_q) * 65536;
				den = cov * 16 + 2 * pc_q;
				f = int'((num + den / 2) / den);
				if (d == scacc_pkg::DIGIT_HIGH) begin
					if (f < e.mn_hi)
						e.mn_hi = f;
					if (e.n_hi < 255) begin
						e.s_hi += f;
						e.n_hi++;
					end
				end else begin
					if (f > e.mx_lo)
						e.mx_lo = f;
					if (e.n_lo < 255) begin
						e.s_lo += f;
						e.n_lo++;
					end
				end
			end
			evidence[s] = e;
		end else begin
			v.site_id = s;
			v.elig = !((e.n_hi == 0 && allow_no_hi_q == 0) ||
				(e.n_lo == 0 && allow_no_lo_q == 0) || e.n_ld > max_ld_q);
			v.pass = 1'b0;
			r = 0;
			if (v.elig) begin
				r = int'(rounded_mean(e.s_hi, e.n_hi)) - int'(rounded_mean(e.s_lo, e.n_lo));
				if (r > 65535)
					r = 65535;
				if (r < -65535)
					r = -65535;
				if (min_gap_q > 0)
					v.pass = (e.mn_hi - e.mx_lo) >= int'(min_gap_q);
				else
					v.pass = e.mx_lo <= int'(band_low_q) && e.mn_hi >= int'(band_high_q);
			end
			v.rank = r[16:0];
			pending_verdicts.push_back(v);
			evidence.delete(s);
		end
	endtask

	// Sends one transaction, then maybe leaves a gap before the next burst.
	task automatic send_item(logic op, logic [15:0] s, logic [15:0] m, logic [15:0] u,
			logic [1:0] d);
		int unsigned gap;
		operation <= op;
		site <= s;
		meth_count <= m;
		unmeth_count <= u;
		group_digit <= d;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		update_evidence(op, s, m, u, d);
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(30, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Only called with the block idle and the input side lowered.
	task automatic write_reg(logic [2:0] idx, int unsigned value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[15:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			scacc_pkg::CFG_PSEUDOCOUNT: pc_q = value & 8'hFF;
			scacc_pkg::CFG_MIN_DEPTH:   min_depth_q = value & 16'hFFFF;
			scacc_pkg::CFG_BAND_LOW:    band_low_q = value & 16'hFFFF;
			scacc_pkg::CFG_BAND_HIGH:   band_high_q = value & 16'hFFFF;
			scacc_pkg::CFG_MIN_GAP:     min_gap_q = value & 16'hFFFF;
			scacc_pkg::CFG_MAX_LOW:     max_ld_q = value & 8'hFF;
			scacc_pkg::CFG_ALLOW_NO_HI: allow_no_hi_q = value & 1;
			scacc_pkg::CFG_ALLOW_NO_LO: allow_no_lo_q = value & 1;
			default: ;
		endcase
	endtask

	task automatic idle_and_configure(int unsigned pc, int unsigned depth, int unsigned blo,
			int unsigned bhi, int unsigned gap, int unsigned ld, int unsigned nh,
			int unsigned nl);
		in_valid <= 1'b0;
		drain();
		write_reg(scacc_pkg::CFG_PSEUDOCOUNT, pc);
		write_reg(scacc_pkg::CFG_MIN_DEPTH, depth);
		write_reg(scacc_pkg::CFG_BAND_LOW, blo);
		write_reg(scacc_pkg::CFG_BAND_HIGH, bhi);
		write_reg(scacc_pkg::CFG_MIN_GAP, gap);
		write_reg(scacc_pkg::CFG_MAX_LOW, ld);
		write_reg(scacc_pkg::CFG_ALLOW_NO_HI, nh);
		write_reg(scacc_pkg::CFG_ALLOW_NO_LO, nl);
	endtask

	function automatic logic [15:0] random_count();
		case ($urandom_range(3))
			0: return 16'($urandom_range(3));
			1: return 16'($urandom_range(40));
			2: return 16'($urandom_range(2000));
			default: return 16'($urandom());
		endcase
	endfunction

	// A well-formed site history: n measurements on either side, now and then an ignored digit, then a verdict.
	task automatic send_site_history(logic [15:0] s, int unsigned n);
		logic [1:0] d;
		logic [15:0] m, u;
		repeat (n) begin
			d = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
			m = random_count();
			u = random_count();
			if ($urandom_range(1)) begin
				if (d == scacc_pkg::DIGIT_HIGH)
					u = u >> $urandom_range(12, 4);
				else
					m = m >> $urandom_range(12, 4);
			end
			send_item(scacc_pkg::OP_ACCUM, s, m, u, d);
		end
		send_item(scacc_pkg::OP_VERDICT, s, 16'($urandom()), 16'($urandom()),
			2'($urandom()));
	endtask

	task automatic test_directed();
		send_item(scacc_pkg::OP_VERDICT, 16'd0, 16'd0, 16'd0, scacc_pkg::DIGIT_LOW);
		send_item(scacc_pkg::OP_ACCUM, 16'd0, 16'hFFFF, 16'd0, scacc_pkg::DIGIT_HIGH);
		send_item(scacc_pkg::OP_ACCUM, 16'd0, 16'd0, 16'hFFFF, scacc_pkg::DIGIT_LOW);
		send_item(scacc_pkg::OP_VERDICT, 16'd0, 16'hFFFF, 16'hFFFF, 2'd3);
		send_item(scacc_pkg::OP_ACCUM, 16'hFFFF, 16'hFFFF, 16'hFFFF, scacc_pkg::DIGIT_HIGH);
		send_item(scacc_pkg::OP_ACCUM, 16'hFFFF, 16'hFFFF, 16'hFFFF, scacc_pkg::DIGIT_LOW);
		send_item(scacc_pkg::OP_ACCUM, 16'hFFFF, 16'd5, 16'd5, 2'd2);
		send_item(scacc_pkg::OP_VERDICT, 16'hFFFF, 16'd0, 16'd0, 2'd0);
		// Zero coverage is below depth; low depth counts whatever the digit.
		send_item(scacc_pkg::OP_ACCUM, 16'd7, 16'd0, 16'd0, 2'd3);
		send_item(scacc_pkg::OP_ACCUM, 16'd7, 16'd9, 16'd1, scacc_pkg::DIGIT_HIGH);
		send_item(scacc_pkg::OP_ACCUM, 16'd7, 16'd1, 16'd9, scacc_pkg::DIGIT_LOW);
		send_item(scacc_pkg::OP_VERDICT, 16'd7, 16'd0, 16'd0, 2'd0);
		idle_and_configure(0, 0, 65535, 0, 0, 255, 1, 1);
		send_item(scacc_pkg::OP_ACCUM, 16'd8, 16'd0, 16'd0, scacc_pkg::DIGIT_HIGH);
		send_item(scacc_pkg::OP_ACCUM, 16'd8, 16'd3, 16'd0, scacc_pkg::DIGIT_HIGH);
		send_item(scacc_pkg::OP_VERDICT, 16'd8, 16'd0, 16'd0, 2'd0);
		send_item(scacc_pkg::OP_VERDICT, 16'd9, 16'd0, 16'd0, 2'd0);
		send_item(scacc_pkg::OP_ACCUM, 16'd10, 16'd0, 16'd4, scacc_pkg::DIGIT_LOW);
		send_item(scacc_pkg::OP_VERDICT, 16'd10, 16'd0, 16'd0, 2'd0);
		idle_and_configure(255, 65535, 0, 65535, 65535, 0, 0, 0);
		send_item(scacc_pkg::OP_ACCUM, 16'd11, 16'hFFFF, 16'd0, scacc_pkg::DIGIT_HIGH);
		send_item(scacc_pkg::OP_ACCUM, 16'd11, 16'd0, 16'hFFFF, scacc_pkg::DIGIT_LOW);
		send_item(scacc_pkg::OP_ACCUM, 16'd11, 16'h100, 16'h10, scacc_pkg::DIGIT_LOW);
		send_item(scacc_pkg::OP_VERDICT, 16'd11, 16'd0, 16'd0, 2'd0);
	endtask

	// Fills one site past the high-side and low-depth counters' ceilings.
	task automatic test_saturation();
		idle_and_configure(16, 2, 30000, 30000, 1, 255, 0, 0);
		repeat (258) send_item(scacc_pkg::OP_ACCUM, 16'd20, 16'hFFFF,
			16'($urandom_range(300)), scacc_pkg::DIGIT_HIGH);
		repeat (258) send_item(scacc_pkg::OP_ACCUM, 16'd20, 16'($urandom_range(1)),
			16'd0, 2'($urandom()));
		send_item(scacc_pkg::OP_ACCUM, 16'd20, 16'd0, 16'hFFFF, scacc_pkg::DIGIT_LOW);
		send_item(scacc_pkg::OP_VERDICT, 16'd20, 16'd0, 16'd0, 2'd0);
	endtask

	task automatic test_backpressure();
		in_valid <= 1'b0;
		drain();
		hold_request = 1'b1;
		for (int i = 0; i < 12; i++)
			send_item(scacc_pkg::OP_VERDICT, 16'(i), 16'($urandom()), 16'($urandom()),
				2'($urandom()));
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 10; phase++) begin
			idle_and_configure($urandom_range(255), $urandom_range(3) == 0 ? $urandom() :
				$urandom_range(20), $urandom(), $urandom(),
				$urandom_range(1) ? 0 : $urandom_range(65535),
				$urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(3),
				$urandom_range(1), $urandom_range(1));
			repeat (8) begin
				if ($urandom_range(4) == 0)
					send_item(1'($urandom()), $urandom_range(1) ? 16'($urandom()) :
						16'($urandom_range(15)), 16'($urandom()), 16'($urandom()),
						2'($urandom()));
				else
					send_site_history(16'($urandom_range(15)), $urandom_range(9));
			end
		end
	endtask

	// Receiver: stall patterns change now and then; a held-off stretch on request.
	always @(posedge clk) begin
		if (cycles % 400 == 0)
			stall_mode <= $urandom_range(3);
		if (hold_request && hold_left == 0) begin
			hold_left <= 2000;
			hold_request <= 1'b0;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1);
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(3) == 0);
				2: out_stall <= ($urandom_range(1) == 0);
				default: out_stall <= ($urandom_range(7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		if (out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("verdict for site %0d with none expected", site_out);
				failures++;
			end else begin
				v = pending_verdicts.pop_front();
				if (site_out !== v.site_id) begin
					$error("site_out: expected %0d, got %0d", v.site_id, site_out);
					failures++;
				end
				if (eligible !== v.elig) begin
					$error("eligible: expected %0d, got %0d", v.elig, eligible);
					failures++;
				end
				if (band_pass !== v.pass) begin
					$error("band_pass: expected %0d, got %0d", v.pass, band_pass);
					failures++;
				end
				if (rank_value !== v.rank) begin
					$error("rank_value: expected %0d, got %0d", v.rank, rank_value);
					failures++;
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_saturation();
		test_random();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;
		drain();
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
